### rtl/core/dcts_pkg.sv
// dcts_pkg: shared types, codes and sizes for the dependency count task scheduler
// used by dcts_count_unit, dcts_seq and dependency_count_task_scheduler
package dcts_pkg;

    localparam int DEFAULT_NODE_COUNT = 16;
    localparam int MAX_SLOTS          = 16;
    localparam int NODE_W             = 4;
    localparam int COUNT_W            = 5;
    localparam int STATUS_W           = 2;
    localparam int CMD_W              = 2;
    localparam int MASK_W             = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_REG      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_GRAPH = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_JOIN_SRC,
        S_JOIN_DST,
        S_EDGE,
        S_FIN,
        S_SCAN,
        S_REPLY
    } t_state;

    typedef enum logic {
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        t_cnt_op            op;
        logic [COUNT_W-1:0] value;
    } t_cnt_req;

    typedef struct packed {
        logic [COUNT_W-1:0] value;
        logic               in_zero;
        logic               out_zero;
    } t_cnt_rsp;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                ready_valid;
        logic [NODE_W-1:0]   ready_node;
        logic                all_done;
        logic                last;
    } t_result;

endpackage

### rtl/core/dcts_count_unit.sv
// dcts_count_unit: shared saturating counter step with zero detect
// depends on dcts_pkg
module dcts_count_unit
    import dcts_pkg::*;
(
    input  t_cnt_req i_req,
    output t_cnt_rsp o_rsp
);

    logic [COUNT_W-1:0] result;
    logic               in_zero;

    always_comb begin
        in_zero = (i_req.value == '0);
        unique case (i_req.op)
            CNT_INC: begin
                result = (i_req.value == COUNT_MAX) ? i_req.value : i_req.value + 1'b1;
            end
            CNT_DEC: begin
                result = in_zero ? i_req.value : i_req.value - 1'b1;
            end
        endcase
    end

    assign o_rsp.value    = result;
    assign o_rsp.in_zero  = in_zero;
    assign o_rsp.out_zero = (result == '0);

endmodule

### rtl/core/dcts_seq.sv
// dcts_seq: command sequencer, graph state and node slot scan
// depends on dcts_pkg and dcts_count_unit
module dcts_seq
    import dcts_pkg::*;
#(
    parameter int NODE_COUNT = DEFAULT_NODE_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [NODE_W-1:0] i_src,
    input  logic [NODE_W-1:0] i_dst,
    input  logic              i_push_ok,
    output logic              o_push,
    output t_result           o_res
);

    localparam int SLOTS = (NODE_COUNT < MAX_SLOTS) ? NODE_COUNT : MAX_SLOTS;
    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [NODE_W:0]    SLOTS_N  = (NODE_W+1)'(SLOTS);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(SLOTS - 1);

    t_state              r_state, n_state;
    logic [MASK_W-1:0]   r_mask;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [NODE_W-1:0]   r_src, n_src;
    logic [NODE_W-1:0]   r_dst, n_dst;
    logic [SLOTS-1:0]    r_in_graph;
    logic [COUNT_W-1:0]  r_remaining;
    logic [COUNT_W-1:0]  r_pending [SLOTS];
    logic [SLOTS-1:0]    r_succ [SLOTS];
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_have, n_have;
    logic [NODE_W-1:0]   r_held, n_held;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_done, n_done;

    t_cnt_req cnt_req;
    t_cnt_rsp cnt_rsp;

    logic              accept;
    logic [IDX_W-1:0]  src_i, dst_i;
    logic              src_in_graph;
    logic [NODE_W-1:0] join_node;
    logic [IDX_W-1:0]  join_i;
    logic              join_in, join_ok;
    logic              succ_bit;
    logic              scan_hit, scan_dec, scan_stall, scan_end;

    // write controls
    logic              graph_set;
    logic              rem_we;
    logic              pend_we;
    logic [IDX_W-1:0]  pend_addr;
    logic              succ_set;

    dcts_count_unit u_count (
        .i_req (cnt_req),
        .o_rsp (cnt_rsp)
    );

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);

    assign src_i        = r_src[IDX_W-1:0];
    assign dst_i        = r_dst[IDX_W-1:0];
    assign src_in_graph = ({1'b0, r_src} < SLOTS_N) && r_in_graph[src_i];

    assign join_node = (r_state == S_JOIN_SRC) ? r_src : r_dst;
    assign join_i    = join_node[IDX_W-1:0];
    assign join_in   = r_in_graph[join_i];
    assign join_ok   = ({1'b0, join_node} < SLOTS_N) && (join_in || r_mask[join_node]);

    assign succ_bit   = r_succ[src_i][r_idx];
    assign scan_end   = (r_idx == LAST_IDX);
    // start: runnable when in graph with no pending work
    // finish: released when a nonzero count drops to zero
    assign scan_dec   = (r_cmd == CMD_FINISH) && succ_bit && !cnt_rsp.in_zero;
    assign scan_hit   = (r_cmd == CMD_FINISH) ? (scan_dec && cnt_rsp.out_zero)
                                              : (r_in_graph[r_idx] && cnt_rsp.in_zero);
    // a hit pushes out the held word, so wait for room
    assign scan_stall = scan_hit && r_have && !i_push_ok;

    // shared counter operand
    always_comb begin
        unique case (r_state)
            S_JOIN_SRC, S_JOIN_DST: begin
                cnt_req.op    = CNT_INC;
                cnt_req.value = r_remaining;
            end
            S_EDGE: begin
                cnt_req.op    = CNT_INC;
                cnt_req.value = r_pending[dst_i];
            end
            S_FIN: begin
                cnt_req.op    = CNT_DEC;
                cnt_req.value = r_remaining;
            end
            default: begin
                cnt_req.op    = CNT_DEC;
                cnt_req.value = r_pending[r_idx];
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_cmd)
                        CMD_ADD:    n_state = S_JOIN_SRC;
                        CMD_START:  n_state = S_SCAN;
                        CMD_FINISH: n_state = S_FIN;
                        default:    n_state = S_REPLY;
                    endcase
                end
            end
            S_JOIN_SRC: begin
                priority if (!join_ok)      n_state = S_REPLY;
                else if (r_src == r_dst)    n_state = S_REPLY;
                else                        n_state = S_JOIN_DST;
            end
            S_JOIN_DST: begin
                n_state = join_ok ? S_EDGE : S_REPLY;
            end
            S_EDGE: begin
                n_state = S_REPLY;
            end
            S_FIN: begin
                priority if (!src_in_graph)   n_state = S_REPLY;
                else if (cnt_rsp.in_zero)     n_state = S_REPLY;
                else if (cnt_rsp.out_zero)    n_state = S_REPLY;
                else                          n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!scan_stall && scan_end) n_state = S_REPLY;
            end
            S_REPLY: begin
                if (i_push_ok) n_state = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd     = r_cmd;
        n_src     = r_src;
        n_dst     = r_dst;
        n_idx     = r_idx;
        n_have    = r_have;
        n_held    = r_held;
        n_status  = r_status;
        n_done    = r_done;
        graph_set = 1'b0;
        rem_we    = 1'b0;
        pend_we   = 1'b0;
        pend_addr = r_idx;
        succ_set  = 1'b0;
        o_push    = 1'b0;
        o_res     = '{status: ST_OK, ready_valid: 1'b1, ready_node: r_held,
                      all_done: 1'b0, last: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = i_cmd;
                    n_src    = i_src;
                    n_dst    = i_dst;
                    n_idx    = '0;
                    n_have   = 1'b0;
                    n_status = ST_OK;
                    n_done   = 1'b0;
                end
            end
            S_JOIN_SRC, S_JOIN_DST: begin
                if (!join_ok) begin
                    n_status = ST_NOT_REG;
                end else if (!join_in) begin
                    graph_set = 1'b1;
                    rem_we    = 1'b1;
                end
            end
            S_EDGE: begin
                pend_addr = dst_i;
                // duplicate edges leave the count alone
                if (!r_succ[src_i][dst_i]) begin
                    succ_set = 1'b1;
                    pend_we  = 1'b1;
                end
            end
            S_FIN: begin
                if (!src_in_graph) begin
                    n_status = ST_NOT_IN_GRAPH;
                end else if (!cnt_rsp.in_zero) begin
                    rem_we = 1'b1;
                    n_done = cnt_rsp.out_zero;
                end
            end
            S_SCAN: begin
                if (!scan_stall) begin
                    pend_we = scan_dec;
                    if (scan_hit) begin
                        o_push = r_have;
                        n_held = NODE_W'(r_idx);
                        n_have = 1'b1;
                    end
                    if (!scan_end) n_idx = r_idx + 1'b1;
                end
            end
            S_REPLY: begin
                o_push = i_push_ok;
                if (r_have) begin
                    o_res.last = 1'b1;
                end else begin
                    o_res = '{status: r_status, ready_valid: 1'b0, ready_node: '0,
                              all_done: r_done, last: 1'b1};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask      <= '0;
            r_in_graph  <= '0;
            r_remaining <= '0;
            r_have      <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_pending[k] <= '0;
                r_succ[k]    <= '0;
            end
        end else begin
            r_state <= n_state;
            r_have  <= n_have;
            if (i_cfg_we) r_mask <= i_cfg_wdata;
            if (graph_set) r_in_graph[join_i] <= 1'b1;
            if (rem_we) r_remaining <= cnt_rsp.value;
            if (pend_we) r_pending[pend_addr] <= cnt_rsp.value;
            if (succ_set) r_succ[src_i][dst_i] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_idx    <= n_idx;
        r_held   <= n_held;
        r_status <= n_status;
        r_done   <= n_done;
    end

endmodule

### rtl/core/dependency_count_task_scheduler.sv
// dependency_count_task_scheduler: top level with the output word register
// depends on dcts_pkg and dcts_seq
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------------------
//  cmd in   | input     | i_in_valid / o_in_stall    | i_command, i_source_node,
//           |           |                            | i_target_node
//  result   | output    | o_out_valid / i_out_stall  | o_status, o_ready_valid,
//           |           |                            | o_ready_node, o_all_done, o_last
//  config   | input     | i_cfg_we                   | i_cfg_wdata (registered mask)
//
//  add goes through the join and edge steps of the sequencer; every reply can be held by i_out_stall
//  start scans the min(NODE_COUNT,16) node slots one per cycle through the shared counter,
//  stalling while the output register is full; a finish checks the remaining count first
//  and scans only if it drops but stays above zero; the unused code goes straight to the reply
//  o_in_stall is high from acceptance until the final word enters the output register
//  synchronous active low reset clears the graph, the counts and the mask
module dependency_count_task_scheduler
    import dcts_pkg::*;
#(
    parameter int NODE_COUNT = DEFAULT_NODE_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [MASK_W-1:0]   i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [NODE_W-1:0]   i_source_node,
    input  logic [NODE_W-1:0]   i_target_node,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_ready_valid,
    output logic [NODE_W-1:0]   o_ready_node,
    output logic                o_all_done,
    output logic                o_last
);

    logic    r_out_valid;
    t_result r_out;
    logic    push_ok;
    logic    push;
    t_result res;

    assign push_ok = !r_out_valid || !i_out_stall;

    dcts_seq #(
        .NODE_COUNT (NODE_COUNT)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_command),
        .i_src       (i_source_node),
        .i_dst       (i_target_node),
        .i_push_ok   (push_ok),
        .o_push      (push),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_out <= res;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_ready_valid = r_out.ready_valid;
    assign o_ready_node  = r_out.ready_node;
    assign o_all_done    = r_out.all_done;
    assign o_last        = r_out.last;

endmodule

### test/dcts_checker.sv
// dcts_checker: watches the command and result channels of the scheduler, predicts every
// result word from its own copy of the graph and compares it; depends on dcts_pkg
`timescale 1ns / 100ps

module dcts_checker
    import dcts_pkg::*;
#(
    parameter int NODE_COUNT = DEFAULT_NODE_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [MASK_W-1:0]   i_cfg_wdata,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [NODE_W-1:0]   i_source_node,
    input  logic [NODE_W-1:0]   i_target_node,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [STATUS_W-1:0] i_status,
    input  logic                i_ready_valid,
    input  logic [NODE_W-1:0]   i_ready_node,
    input  logic                i_all_done,
    input  logic                i_last,
    output int                  o_fail_count,
    output int                  o_pending_words,
    output int                  o_word_count
);

    logic [MASK_W-1:0]    reg_mask;
    logic [MASK_W-1:0]    graph_mask;
    logic [MAX_SLOTS-1:0] succ_rows [MAX_SLOTS];
    logic [COUNT_W-1:0]   pend_count [MAX_SLOTS];
    logic [COUNT_W-1:0]   nodes_left;

    t_result expected_words[$];
    int      fail_count;
    int      word_count;

    assign o_fail_count    = fail_count;
    assign o_pending_words = expected_words.size();
    assign o_word_count    = word_count;

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= 40) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
    endtask

    task automatic push_word(input logic [STATUS_W-1:0] status, input logic rv,
                             input logic [NODE_W-1:0] node, input logic done,
                             input logic last);
        t_result w;
        w.status      = status;
        w.ready_valid = rv;
        w.ready_node  = node;
        w.all_done    = done;
        w.last        = last;
        expected_words.push_back(w);
    endtask

    // a node already in the graph joins without looking at the registered mask
    function automatic bit join_node(input int n);
        if (n >= NODE_COUNT) return 1'b0;
        if (graph_mask[n]) return 1'b1;
        if (!reg_mask[n]) return 1'b0;
        graph_mask[n] = 1'b1;
        if (nodes_left < COUNT_MAX) nodes_left = nodes_left + 1'b1;
        return 1'b1;
    endfunction

    // ready nodes go out in index order, last set on the final one
    task automatic push_ready_list(input int ready[$]);
        if (ready.size() == 0) begin
            push_word(ST_OK, 1'b0, '0, 1'b0, 1'b1);
        end else begin
            foreach (ready[k]) begin
                push_word(ST_OK, 1'b1, NODE_W'(ready[k]), 1'b0, k == ready.size() - 1);
            end
        end
    endtask

    task automatic predict_command(input logic [CMD_W-1:0] cmd,
                                   input logic [NODE_W-1:0] src,
                                   input logic [NODE_W-1:0] tgt);
        int ready[$];
        case (cmd)
            CMD_ADD: begin
                if (!join_node(int'(src))) begin
                    push_word(ST_NOT_REG, 1'b0, '0, 1'b0, 1'b1);
                end else if (src != tgt && !join_node(int'(tgt))) begin
                    push_word(ST_NOT_REG, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    // duplicate edges leave the count alone
                    if (src != tgt && !succ_rows[src][tgt]) begin
                        succ_rows[src][tgt] = 1'b1;
                        if (pend_count[tgt] < COUNT_MAX) begin
                            pend_count[tgt] = pend_count[tgt] + 1'b1;
                        end
                    end
                    push_word(ST_OK, 1'b0, '0, 1'b0, 1'b1);
                end
            end
            CMD_START: begin
                for (int i = 0; i < NODE_COUNT && i < MAX_SLOTS; i++) begin
                    if (graph_mask[i] && pend_count[i] == 0) ready.push_back(i);
                end
                push_ready_list(ready);
            end
            CMD_FINISH: begin
                if (int'(src) >= NODE_COUNT || !graph_mask[src]) begin
                    push_word(ST_NOT_IN_GRAPH, 1'b0, '0, 1'b0, 1'b1);
                end else if (nodes_left == 0) begin
                    push_word(ST_OK, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    nodes_left = nodes_left - 1'b1;
                    if (nodes_left == 0) begin
                        push_word(ST_OK, 1'b0, '0, 1'b1, 1'b1);
                    end else begin
                        for (int i = 0; i < NODE_COUNT && i < MAX_SLOTS; i++) begin
                            if (succ_rows[src][i] && pend_count[i] > 0) begin
                                pend_count[i] = pend_count[i] - 1'b1;
                                if (pend_count[i] == 0) ready.push_back(i);
                            end
                        end
                        push_ready_list(ready);
                    end
                end
            end
            default: begin
                push_word(ST_OK, 1'b0, '0, 1'b0, 1'b1);
            end
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            reg_mask   = '0;
            graph_mask = '0;
            nodes_left = '0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                succ_rows[i]  = '0;
                pend_count[i] = '0;
            end
            expected_words.delete();
            fail_count = 0;
            word_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.status      = i_status;
                got.ready_valid = i_ready_valid;
                got.ready_node  = i_ready_node;
                got.all_done    = i_all_done;
                got.last        = i_last;
                word_count++;
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("result word %0d with nothing expected",
                                              word_count));
                end else begin
                    want = expected_words.pop_front();
                    if (got.status !== want.status || got.ready_valid !== want.ready_valid ||
                        got.ready_node !== want.ready_node ||
                        got.all_done !== want.all_done || got.last !== want.last) begin
                        report_mismatch($sformatf(
                            "word %0d got %0d %0d %0d %0d %0d want %0d %0d %0d %0d %0d",
                            word_count, got.status, got.ready_valid, got.ready_node,
                            got.all_done, got.last, want.status, want.ready_valid,
                            want.ready_node, want.all_done, want.last));
                    end
                end
            end
            if (i_cfg_we) begin
                reg_mask = i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_command(i_command, i_source_node, i_target_node);
            end
        end
    end

endmodule

### test/tb_dependency_count_task_scheduler.sv
// tb_dependency_count_task_scheduler: drives commands, mask writes and output stalls into
// the scheduler; depends on dcts_pkg, dependency_count_task_scheduler and dcts_checker
`timescale 1ns / 100ps

module tb_dependency_count_task_scheduler;
    import dcts_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int ROUND_WORDS      = 75;
    localparam int LONG_HOLD_CYCLES = 300;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [MASK_W-1:0]   i_cfg_wdata   = '0;
    logic                i_in_valid    = 1'b0;
    logic [CMD_W-1:0]    i_command     = '0;
    logic [NODE_W-1:0]   i_source_node = '0;
    logic [NODE_W-1:0]   i_target_node = '0;
    logic                i_out_stall   = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic                o_ready_valid;
    logic [NODE_W-1:0]   o_ready_node;
    logic                o_all_done;
    logic                o_last;

    int fail_count;
    int pending_words;
    int word_count;

    bit                long_hold_req = 1'b0;
    bit                calm          = 1'b0;
    int                words_sent    = 0;
    int                mask_writes   = 0;
    logic [MASK_W-1:0] used_nodes    = '0;

    dependency_count_task_scheduler i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_source_node (i_source_node),
        .i_target_node (i_target_node),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_ready_valid (o_ready_valid),
        .o_ready_node  (o_ready_node),
        .o_all_done    (o_all_done),
        .o_last        (o_last)
    );

    dcts_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_source_node   (i_source_node),
        .i_target_node   (i_target_node),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_status        (o_status),
        .i_ready_valid   (o_ready_valid),
        .i_ready_node    (o_ready_node),
        .i_all_done      (o_all_done),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending_words (pending_words),
        .o_word_count    (word_count)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    initial begin : watchdog
        #1000000;
        $display("tb: failure");
        $finish;
    end

    // result side: random stall bursts, one long hold on request, none once calm
    initial begin : receiver_idling
        int  left;
        bit  level;
        left  = 0;
        level = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                level = 1'b1;
                left  = LONG_HOLD_CYCLES;
            end else if (calm) begin
                level = 1'b0;
                left  = 0;
            end else if (left == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    level = 1'b1;
                    left  = $urandom_range(1, 19);
                end else begin
                    level = 1'b0;
                    left  = $urandom_range(1, 40);
                end
            end
            i_out_stall <= level;
            if (left > 0) left--;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance, valid still high
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] src,
                             input logic [NODE_W-1:0] tgt);
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_source_node <= src;
        i_target_node <= tgt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic sender_gap(input int pct);
        if ($urandom_range(0, 99) < pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_words != 0) @(negedge i_clk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] value);
        drain_results();
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mask_writes++;
    endtask

    // edge between two pool nodes, lower index first so the graph stays acyclic
    task automatic send_pool_edge(input int pool[$]);
        int a;
        int b;
        int t;
        a = pool[$urandom_range(0, pool.size() - 1)];
        b = pool[$urandom_range(0, pool.size() - 1)];
        if (a > b) begin
            t = a;
            a = b;
            b = t;
        end
        send_word(CMD_ADD, NODE_W'(a), NODE_W'(b));
    endtask

    task automatic run_round(input logic [MASK_W-1:0] fresh, input bit full_mask,
                             input int gap_pct, input int drain_at, input bit hold);
        int                pool[$];
        int                step;
        int                sz;
        logic [MASK_W-1:0] mask;
        mask = full_mask ? {MASK_W{1'b1}} : (fresh | (MASK_W'($urandom) & used_nodes));
        write_mask(mask);
        for (int n = 0; n < MASK_W; n++) begin
            if (fresh[n] || (used_nodes[n] && $urandom_range(0, 2) == 0)) pool.push_back(n);
        end
        used_nodes = used_nodes | fresh;
        sz   = pool.size();
        step = 0;
        if (hold) long_hold_req = 1'b1;
        for (int cnt = 0; cnt < ROUND_WORDS; cnt++) begin
            if (cnt == drain_at) drain_results();
            sender_gap(gap_pct);
            if ($urandom_range(0, 3) == 0) begin
                send_word(CMD_W'($urandom_range(0, 3)), NODE_W'($urandom), NODE_W'($urandom));
            end else begin
                if (step < sz) begin
                    // bring every pool node in, self edge when both picks agree
                    send_word(CMD_ADD, NODE_W'(pool[$urandom_range(0, step)]),
                              NODE_W'(pool[step]));
                end else if (step < 3 * sz) begin
                    send_pool_edge(pool);
                end else if (step == 3 * sz) begin
                    send_word(CMD_START, NODE_W'($urandom), NODE_W'($urandom));
                end else if (step <= 4 * sz) begin
                    send_word(CMD_FINISH, NODE_W'(pool[step - 3 * sz - 1]), NODE_W'($urandom));
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: send_pool_edge(pool);
                        5, 6, 7: send_word(CMD_FINISH, NODE_W'(pool[$urandom_range(0, sz - 1)]),
                                           NODE_W'($urandom));
                        default: send_word(CMD_START, NODE_W'($urandom), NODE_W'($urandom));
                    endcase
                end
                step++;
            end
        end
    endtask

    initial begin : stimulus
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // nothing registered: every command lands on an error or an empty reply
        write_mask('0);
        send_word(CMD_ADD, 4'd3, 4'd5);
        send_word(CMD_ADD, 4'd15, 4'd15);
        send_word(CMD_START, 4'd0, 4'd0);
        send_word(CMD_FINISH, 4'd3, 4'd0);
        send_word(CMD_UNUSED, 4'd15, 4'd15);

        // small diamond plus a lone self edge, run to completion
        write_mask(16'h003F);
        used_nodes = 16'h003F;
        send_word(CMD_ADD, 4'd0, 4'd1);
        send_word(CMD_ADD, 4'd0, 4'd2);
        sender_gap(50);
        send_word(CMD_ADD, 4'd1, 4'd3);
        send_word(CMD_ADD, 4'd2, 4'd3);
        send_word(CMD_ADD, 4'd0, 4'd1);
        send_word(CMD_ADD, 4'd4, 4'd4);
        send_word(CMD_ADD, 4'd5, 4'd12);
        send_word(CMD_ADD, 4'd12, 4'd0);
        send_word(CMD_START, 4'd15, 4'd15);
        sender_gap(50);
        send_word(CMD_FINISH, 4'd0, 4'd15);
        send_word(CMD_FINISH, 4'd1, 4'd0);
        send_word(CMD_FINISH, 4'd2, 4'd0);
        send_word(CMD_FINISH, 4'd3, 4'd0);
        send_word(CMD_FINISH, 4'd4, 4'd0);
        send_word(CMD_FINISH, 4'd5, 4'd0);
        send_word(CMD_FINISH, 4'd2, 4'd0);
        send_word(CMD_FINISH, 4'd9, 4'd0);

        run_round(16'h01C0, 1'b0, 30, -1, 1'b0);
        run_round(16'h0E00, 1'b0, 15, -1, 1'b1);
        run_round(16'h3000, 1'b0, 20, 35, 1'b0);
        calm = 1'b1;
        run_round(16'hC000, 1'b1, 0, -1, 1'b0);

        drain_results();
        repeat (40) @(negedge i_clk);

        $display("summary: %0d commands, %0d result words checked, %0d mask settings",
                 words_sent, word_count, mask_writes);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/dcts_pkg.sv
rtl/core/dcts_count_unit.sv
rtl/core/dcts_seq.sv
rtl/core/dependency_count_task_scheduler.sv
test/dcts_checker.sv
test/tb_dependency_count_task_scheduler.sv
